FILE: src/fskc_pkg.sv
// fskc_pkg: shared types and constants for the noncoherent FSK correlator.
// No dependencies; used by every module under src.
package fskc_pkg;

    localparam int TUNING_BITS    = 31;
    localparam int THRESH_BITS    = 64;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int REF_BITS       = 16;   // Q15 reference, signed

    localparam logic [TUNING_BITS-1:0] MARK_TW_RESET  = 31'd939524096;
    localparam logic [TUNING_BITS-1:0] SPACE_TW_RESET = 31'd1028980053;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET   = 64'd0;

    // pi/2 in Q30 and the Taylor series divisors (2n)(2n+1) for sine
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 12;
    localparam logic [9:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
          10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600};
    localparam logic [63:0] Q15_MAX = 64'd32767;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MARK_TW  = 2'd0,
        CFG_SPACE_TW = 2'd1,
        CFG_THRESH   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_DETECT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        DEC_IDLE     = 2'd0,
        DEC_DECIDING = 2'd1,
        DEC_MARK     = 2'd2,
        DEC_SPACE    = 2'd3
    } decision_t;

    // stage enables for the correlator front end
    typedef struct packed {
        logic phase_step;   // sample request accepted, advance NCO
        logic a_load;       // index register
        logic b_load;       // ROM output register
        logic c_load;       // product register
        logic acc_add;      // sample leaves product stage
        logic acc_dump;     // detect leaves product stage: snapshot and clear
    } corr_ctl_t;

    // stage enables for the energy pipeline
    typedef struct packed {
        logic e1_load;
        logic e2_load;
        logic e3_load;
        logic e4_load;
    } energy_ctl_t;

endpackage

FILE: src/fskc_sine_rom.sv
// fskc_sine_rom: full-cycle Q15 sine lookup, two read ports, registered output.
// Quarter-wave table is built at elaboration; depends on fskc_pkg.
module fskc_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [ADDR_BITS-1:0]                  addr_a,
    input  logic [ADDR_BITS-1:0]                  addr_b,
    output logic signed [fskc_pkg::REF_BITS-1:0]  data_a,
    output logic signed [fskc_pkg::REF_BITS-1:0]  data_b
);

    localparam int Quarter = 1 << (ADDR_BITS - 2);

    typedef logic [fskc_pkg::REF_BITS-2:0] qtab_t [Quarter+1];

    // Integer Taylor series in Q30, rounded to Q15 and capped
    function automatic qtab_t build_qtab();
        qtab_t       tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q15;
        for (int j = 0; j <= Quarter; j++)
        begin
            x    = (fskc_pkg::HALF_PI_Q30 * 64'(j) + 64'(Quarter / 2)) / 64'(Quarter);
            term = x;
            sum  = x;
            for (int n = 1; n <= fskc_pkg::TAYLOR_TERMS; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'(fskc_pkg::TAYLOR_DIV[n-1]);
                if ((n & 1) != 0)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            q15 = (sum * fskc_pkg::Q15_MAX + 64'd536870912) >> 30;
            if (q15 > fskc_pkg::Q15_MAX)
                q15 = fskc_pkg::Q15_MAX;
            tab[j] = q15[fskc_pkg::REF_BITS-2:0];
        end
        return tab;
    endfunction

    localparam qtab_t QTab = build_qtab();

    function automatic logic signed [fskc_pkg::REF_BITS-1:0] lookup(
        input logic [ADDR_BITS-1:0] k
    );
        logic [ADDR_BITS-3:0]          j;
        logic [ADDR_BITS-2:0]          q;
        logic [fskc_pkg::REF_BITS-1:0] mag;
        j   = k[ADDR_BITS-3:0];
        // odd quadrants run the quarter table backwards
        q   = k[ADDR_BITS-2] ? ((ADDR_BITS-1)'(Quarter) - {1'b0, j}) : {1'b0, j};
        mag = {1'b0, QTab[q]};
        return k[ADDR_BITS-1] ? -$signed(mag) : $signed(mag);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a <= lookup(addr_a);
            data_b <= lookup(addr_b);
        end
    end

endmodule

FILE: src/fskc_tone_corr.sv
// fskc_tone_corr: one tone's NCO, sine/cosine lookup, products and accumulators.
// Depends on fskc_pkg and fskc_sine_rom.
module fskc_tone_corr #(
    parameter int PHASE_BITS  = 31,
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_BITS   = 10,
    parameter int ACC_BITS    = 40
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fskc_pkg::corr_ctl_t                 ctl,
    input  logic [fskc_pkg::TUNING_BITS-1:0]    tuning_word,
    input  logic signed [SAMPLE_BITS-1:0]       b_sample,
    output logic [ACC_BITS-1:0]                 sin_snap,
    output logic [ACC_BITS-1:0]                 cos_snap
);

    localparam int ProdBits = SAMPLE_BITS + fskc_pkg::REF_BITS;

    logic [PHASE_BITS-1:0]               phase_reg;
    logic [PHASE_BITS-1:0]               phase_next;
    logic [ADDR_BITS-1:0]                idx_reg;
    logic [ADDR_BITS-1:0]                cos_idx;
    logic signed [fskc_pkg::REF_BITS-1:0] sin_ref;
    logic signed [fskc_pkg::REF_BITS-1:0] cos_ref;
    logic signed [ProdBits-1:0]          sin_prod_reg;
    logic signed [ProdBits-1:0]          cos_prod_reg;
    logic [ACC_BITS-1:0]                 sin_acc_reg;
    logic [ACC_BITS-1:0]                 cos_acc_reg;
    logic [ACC_BITS-1:0]                 sin_snap_reg;
    logic [ACC_BITS-1:0]                 cos_snap_reg;

    // phase advances first, the new phase addresses the table
    assign phase_next = phase_reg + PHASE_BITS'(tuning_word);
    assign cos_idx    = idx_reg + (ADDR_BITS'(1) << (ADDR_BITS - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            sin_acc_reg <= '0;
            cos_acc_reg <= '0;
        end
        else
        begin
            if (ctl.phase_step)
                phase_reg <= phase_next;
            if (ctl.acc_dump)
            begin
                sin_acc_reg <= '0;
                cos_acc_reg <= '0;
            end
            else if (ctl.acc_add)
            begin
                sin_acc_reg <= sin_acc_reg + ACC_BITS'(sin_prod_reg);
                cos_acc_reg <= cos_acc_reg + ACC_BITS'(cos_prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.a_load)
            idx_reg <= phase_next[PHASE_BITS-1 -: ADDR_BITS];
        if (ctl.c_load)
        begin
            sin_prod_reg <= b_sample * sin_ref;
            cos_prod_reg <= b_sample * cos_ref;
        end
        if (ctl.acc_dump)
        begin
            sin_snap_reg <= sin_acc_reg;
            cos_snap_reg <= cos_acc_reg;
        end
    end

    fskc_sine_rom #(
        .ADDR_BITS (ADDR_BITS)
    ) u_rom (
        .clk    (clk),
        .en     (ctl.b_load),
        .addr_a (idx_reg),
        .addr_b (cos_idx),
        .data_a (sin_ref),
        .data_b (cos_ref)
    );

    assign sin_snap = sin_snap_reg;
    assign cos_snap = cos_snap_reg;

endmodule

FILE: src/fskc_tone_energy.sv
// fskc_tone_energy: four-stage pipeline, (sin^2 + cos^2) >> shift, saturated to 64 bits.
// Squares are split into half-width partial products; depends on fskc_pkg.
module fskc_tone_energy #(
    parameter int ACC_BITS     = 40,
    parameter int ENERGY_SHIFT = 8
) (
    input  logic                                clk,
    input  fskc_pkg::energy_ctl_t               ctl,
    input  logic [ACC_BITS-1:0]                 sin_acc,
    input  logic [ACC_BITS-1:0]                 cos_acc,
    output logic [fskc_pkg::THRESH_BITS-1:0]    energy
);

    localparam int LoBits  = (ACC_BITS + 1) / 2;
    localparam int HiBits  = ACC_BITS - LoBits;
    localparam int SqBits  = 2 * ACC_BITS;
    localparam int SumBits = SqBits + 1;
    localparam int EBits   = fskc_pkg::THRESH_BITS;

    logic [ACC_BITS-1:0]        sin_mag_reg;
    logic [ACC_BITS-1:0]        cos_mag_reg;
    logic [2*HiBits-1:0]        sin_hh_reg;
    logic [HiBits+LoBits-1:0]   sin_hl_reg;
    logic [2*LoBits-1:0]        sin_ll_reg;
    logic [2*HiBits-1:0]        cos_hh_reg;
    logic [HiBits+LoBits-1:0]   cos_hl_reg;
    logic [2*LoBits-1:0]        cos_ll_reg;
    logic [SqBits-1:0]          sin_sq_reg;
    logic [SqBits-1:0]          cos_sq_reg;
    logic [SumBits-1:0]         sum;
    logic [SumBits-1:0]         shifted;
    logic [EBits-1:0]           energy_reg;

    function automatic logic [ACC_BITS-1:0] magnitude(input logic [ACC_BITS-1:0] a);
        return a[ACC_BITS-1] ? (~a + ACC_BITS'(1)) : a;
    endfunction

    assign sum     = SumBits'(sin_sq_reg) + SumBits'(cos_sq_reg);
    assign shifted = sum >> ENERGY_SHIFT;

    always_ff @(posedge clk)
    begin
        if (ctl.e1_load)
        begin
            sin_mag_reg <= magnitude(sin_acc);
            cos_mag_reg <= magnitude(cos_acc);
        end
        if (ctl.e2_load)
        begin
            sin_hh_reg <= sin_mag_reg[ACC_BITS-1:LoBits] * sin_mag_reg[ACC_BITS-1:LoBits];
            sin_hl_reg <= sin_mag_reg[ACC_BITS-1:LoBits] * sin_mag_reg[LoBits-1:0];
            sin_ll_reg <= sin_mag_reg[LoBits-1:0] * sin_mag_reg[LoBits-1:0];
            cos_hh_reg <= cos_mag_reg[ACC_BITS-1:LoBits] * cos_mag_reg[ACC_BITS-1:LoBits];
            cos_hl_reg <= cos_mag_reg[ACC_BITS-1:LoBits] * cos_mag_reg[LoBits-1:0];
            cos_ll_reg <= cos_mag_reg[LoBits-1:0] * cos_mag_reg[LoBits-1:0];
        end
        if (ctl.e3_load)
        begin
            // (h*2^L + l)^2 = hh*2^2L + 2*hl*2^L + ll
            sin_sq_reg <= (SqBits'(sin_hh_reg) << (2 * LoBits))
                        + (SqBits'(sin_hl_reg) << (LoBits + 1))
                        + SqBits'(sin_ll_reg);
            cos_sq_reg <= (SqBits'(cos_hh_reg) << (2 * LoBits))
                        + (SqBits'(cos_hl_reg) << (LoBits + 1))
                        + SqBits'(cos_ll_reg);
        end
        if (ctl.e4_load)
            energy_reg <= (|shifted[SumBits-1:EBits]) ? '1 : shifted[EBits-1:0];
    end

    assign energy = energy_reg;

endmodule

FILE: src/noncoherent_fsk_correlator_top.sv
// noncoherent_fsk_correlator_top: request pipeline, configuration, window voting.
// Depends on fskc_pkg, fskc_tone_corr and fskc_tone_energy.
//
// One request (sample or detect) is taken every clock while the pipeline can move;
// a sample request never produces a result, a detect request produces exactly one
// decision, which passes the a, b, c, d, e1-e4 and output registers before it is
// presented. The accumulators add in place, so while the pipeline can move the
// sustained rate is one request per cycle; a stalled result only holds back input
// once every stage behind it is full.
// Sine/cosine come from an elaboration-time quarter-wave table; the two tone
// energies are squared through half-width partial products over four stages.
// Configuration writes take effect at once and are meant for an idle block.
module noncoherent_fsk_correlator_top #(
    parameter int PHASE_BITS      = 31,
    parameter int SAMPLE_BITS     = 16,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int ACC_BITS        = 40,
    parameter int ENERGY_SHIFT    = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [fskc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fskc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic signed [SAMPLE_BITS-1:0]          sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             bit_decision
);

    localparam int TwBits = fskc_pkg::TUNING_BITS;
    localparam int ThBits = fskc_pkg::THRESH_BITS;

    logic [TwBits-1:0]   mark_tw_reg;
    logic [TwBits-1:0]   space_tw_reg;
    logic [ThBits-1:0]   thresh_reg;

    // pipeline valid bits and detect flags
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic e1_valid_reg, e2_valid_reg, e3_valid_reg, e4_valid_reg;
    logic a_det_reg, b_det_reg, c_det_reg;
    logic out_valid_reg;
    logic load_a, load_b, load_c, load_d;
    logic load_e1, load_e2, load_e3, load_e4, load_out;

    logic signed [SAMPLE_BITS-1:0] a_sample_reg;
    logic signed [SAMPLE_BITS-1:0] b_sample_reg;

    fskc_pkg::corr_ctl_t   corr_ctl;
    fskc_pkg::energy_ctl_t energy_ctl;

    logic [ACC_BITS-1:0] mark_sin_snap, mark_cos_snap;
    logic [ACC_BITS-1:0] space_sin_snap, space_cos_snap;
    logic [ThBits-1:0]   mark_energy, space_energy;

    logic [1:0] mark_votes_reg, space_votes_reg, window_reg;
    logic [1:0] mark_votes_next, space_votes_next, window_next;
    logic       mark_hit, space_hit;
    fskc_pkg::decision_t decision_reg, decision_next;

    // A stage may load when it is empty or its request moves on.
    // Samples are consumed at the accumulators; only detects go further.
    assign load_out = !out_valid_reg || out_ready;
    assign load_e4  = !e4_valid_reg || load_out;
    assign load_e3  = !e3_valid_reg || load_e4;
    assign load_e2  = !e2_valid_reg || load_e3;
    assign load_e1  = !e1_valid_reg || load_e2;
    assign load_d   = !d_valid_reg || load_e1;
    assign load_c   = !c_valid_reg || !c_det_reg || load_d;
    assign load_b   = !b_valid_reg || load_c;
    assign load_a   = !a_valid_reg || load_b;
    assign in_ready = load_a;

    always_comb
    begin
        corr_ctl.phase_step = in_valid && load_a && (action == fskc_pkg::ACT_SAMPLE);
        corr_ctl.a_load     = load_a;
        corr_ctl.b_load     = load_b;
        corr_ctl.c_load     = load_c;
        corr_ctl.acc_add    = c_valid_reg && !c_det_reg;
        corr_ctl.acc_dump   = c_valid_reg && c_det_reg && load_d;
        energy_ctl.e1_load  = load_e1;
        energy_ctl.e2_load  = load_e2;
        energy_ctl.e3_load  = load_e3;
        energy_ctl.e4_load  = load_e4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_tw_reg  <= fskc_pkg::MARK_TW_RESET;
            space_tw_reg <= fskc_pkg::SPACE_TW_RESET;
            thresh_reg   <= fskc_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fskc_pkg::CFG_MARK_TW:  mark_tw_reg  <= cfg_data[TwBits-1:0];
                fskc_pkg::CFG_SPACE_TW: space_tw_reg <= cfg_data[TwBits-1:0];
                fskc_pkg::CFG_THRESH:   thresh_reg   <= cfg_data[ThBits-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            e4_valid_reg  <= 1'b0;
            a_det_reg     <= 1'b0;
            b_det_reg     <= 1'b0;
            c_det_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_a)
            begin
                a_valid_reg <= in_valid;
                a_det_reg   <= (action == fskc_pkg::ACT_DETECT);
            end
            if (load_b)
            begin
                b_valid_reg <= a_valid_reg;
                b_det_reg   <= a_det_reg;
            end
            if (load_c)
            begin
                c_valid_reg <= b_valid_reg;
                c_det_reg   <= b_det_reg;
            end
            if (load_d)
                d_valid_reg <= c_valid_reg && c_det_reg;
            if (load_e1)
                e1_valid_reg <= d_valid_reg;
            if (load_e2)
                e2_valid_reg <= e1_valid_reg;
            if (load_e3)
                e3_valid_reg <= e2_valid_reg;
            if (load_e4)
                e4_valid_reg <= e3_valid_reg;
            if (load_out)
                out_valid_reg <= e4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
            a_sample_reg <= sample;
        if (load_b)
            b_sample_reg <= a_sample_reg;
    end

    fskc_tone_corr #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (TABLE_ADDR_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_mark_corr (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (corr_ctl),
        .tuning_word (mark_tw_reg),
        .b_sample    (b_sample_reg),
        .sin_snap    (mark_sin_snap),
        .cos_snap    (mark_cos_snap)
    );

    fskc_tone_corr #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (TABLE_ADDR_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_space_corr (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (corr_ctl),
        .tuning_word (space_tw_reg),
        .b_sample    (b_sample_reg),
        .sin_snap    (space_sin_snap),
        .cos_snap    (space_cos_snap)
    );

    fskc_tone_energy #(
        .ACC_BITS     (ACC_BITS),
        .ENERGY_SHIFT (ENERGY_SHIFT)
    ) u_mark_energy (
        .clk     (clk),
        .ctl     (energy_ctl),
        .sin_acc (mark_sin_snap),
        .cos_acc (mark_cos_snap),
        .energy  (mark_energy)
    );

    fskc_tone_energy #(
        .ACC_BITS     (ACC_BITS),
        .ENERGY_SHIFT (ENERGY_SHIFT)
    ) u_space_energy (
        .clk     (clk),
        .ctl     (energy_ctl),
        .sin_acc (space_sin_snap),
        .cos_acc (space_cos_snap),
        .energy  (space_energy)
    );

    // window voting: first hit opens a three-window vote that may settle a bit
    always_comb
    begin
        mark_hit         = mark_energy > thresh_reg;
        space_hit        = space_energy > thresh_reg;
        mark_votes_next  = mark_votes_reg + {1'b0, mark_hit};
        space_votes_next = space_votes_reg + {1'b0, space_hit};
        window_next      = window_reg;
        if (mark_hit || space_hit || (window_reg != 2'd0))
            window_next = window_reg + 2'd1;

        if (window_next > 2'd2)
        begin
            if ((mark_votes_next > space_votes_next) && (mark_votes_next > 2'd1))
                decision_next = fskc_pkg::DEC_MARK;
            else if ((space_votes_next > mark_votes_next) && (space_votes_next > 2'd1))
                decision_next = fskc_pkg::DEC_SPACE;
            else
                decision_next = fskc_pkg::DEC_IDLE;
            mark_votes_next  = 2'd0;
            space_votes_next = 2'd0;
            window_next      = 2'd0;
        end
        else if (window_next != 2'd0)
            decision_next = fskc_pkg::DEC_DECIDING;
        else
            decision_next = fskc_pkg::DEC_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_votes_reg  <= 2'd0;
            space_votes_reg <= 2'd0;
            window_reg      <= 2'd0;
        end
        else if (e4_valid_reg && load_out)
        begin
            mark_votes_reg  <= mark_votes_next;
            space_votes_reg <= space_votes_next;
            window_reg      <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e4_valid_reg && load_out)
            decision_reg <= decision_next;
    end

    assign out_valid    = out_valid_reg;
    assign bit_decision = decision_reg;

endmodule
